FILE: sv/tkut_pkg.sv
// shared types and constants for the top-k usage tracker
`timescale 1ns / 1ps

package tkut_pkg;

    // list depth and field widths
    localparam int ENTRIES  = 10;
    localparam int GB_W     = 20;
    localparam int MB_W     = 10;
    localparam int BY_W     = 20;
    localparam int HOUR_W   = 5;
    localparam int VALUE_W  = GB_W + MB_W + BY_W;
    localparam int RANK_W   = 4;
    localparam int CNT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // stream widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 64;

    // request kinds carried on s_tuser
    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_DUMP  = 1'b1;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [HOUR_W-1:0]  hour_t;

    // one list entry, value packed gb:mb:bytes from the top
    typedef struct packed {
        value_t value;
        hour_t  hour;
    } entry_t;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic offer_en;
        logic dump_en;
    } cell_ctrl_t;

endpackage

FILE: sv/tkut_cell.sv
// one cell of the sorted insertion chain, holds a single list entry
`timescale 1ns / 1ps

module tkut_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  tkut_pkg::cell_ctrl_t ctrl,
    input  tkut_pkg::value_t    offer_value,
    input  tkut_pkg::hour_t     offer_hour,
    input  tkut_pkg::entry_t    left_entry,
    input  logic                left_gt,
    input  tkut_pkg::entry_t    right_entry,
    output tkut_pkg::entry_t    entry,
    output logic                gt
);

    tkut_pkg::entry_t entry_reg;
    tkut_pkg::entry_t entry_next;

    // offer beats this entry
    assign gt = offer_value > entry_reg.value;

    // dump: shift from the right; insert: shift from the left if the left also lost, else take the offer
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.dump_en) begin
            entry_next = right_entry;
        end else if (ctrl.offer_en && gt) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else begin
                entry_next.value = offer_value;
                entry_next.hour  = offer_hour;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: sv/top_k_usage_tracker_top.sv
// top level: chain of list cells, request control and result register
// an offer's result is registered when its beat is accepted
// throughput: one offer per cycle while the result side keeps up and no dump is running
// a dump enters the dump state on its beat, then registers one entry per cycle while the result side keeps up,
// holds off the input until its last entry and shifts zeros in from the tail
// reset (aresetn low, synchronous) clears the list to zeros and the result side
`timescale 1ns / 1ps

module top_k_usage_tracker_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // gigabytes_in[19:0], megabytes_in[29:20], bytes_in[49:30], hour_in[54:50]
    input  logic [tkut_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted[0], rank[4:1], gigabytes_out[24:5], megabytes_out[34:25],
    // bytes_out[54:35], hour_out[59:55]
    output logic [tkut_pkg::M_DATA_W-1:0]   m_tdata,
    // is_dump_entry[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    state_t                      state_reg;
    logic [tkut_pkg::CNT_W-1:0]  cnt_reg;
    logic                        m_tvalid_reg;
    logic [tkut_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                        m_tuser_reg;
    logic                        m_tlast_reg;

    logic                        out_free;
    logic                        in_accept;
    logic                        dump_step;
    tkut_pkg::cell_ctrl_t        ctrl;

    tkut_pkg::value_t            offer_value;
    tkut_pkg::hour_t             offer_hour;

    tkut_pkg::entry_t            cell_entry [tkut_pkg::ENTRIES];
    logic [tkut_pkg::ENTRIES-1:0] cell_gt;
    logic [tkut_pkg::ENTRIES-1:0] ins_pt;
    logic [tkut_pkg::RANK_W-1:0] ins_rank;
    logic                        placed;
    logic [tkut_pkg::RANK_W-1:0] offer_rank;

    // offer fields, value packed gb:mb:bytes
    assign offer_value = {s_tdata[19:0], s_tdata[29:20], s_tdata[49:30]};
    assign offer_hour  = s_tdata[54:50];

    // handshake
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign dump_step = (state_reg == ST_DUMP) && out_free;

    assign ctrl.offer_en = in_accept && (s_tuser == tkut_pkg::REQ_OFFER);
    assign ctrl.dump_en  = dump_step;

    // cell chain
    for (genvar i = 0; i < tkut_pkg::ENTRIES; i++) begin : g_cell
        tkut_pkg::entry_t left_entry;
        tkut_pkg::entry_t right_entry;
        logic             left_gt;

        if (i == 0) begin : g_head
            assign left_entry = '0;
            assign left_gt    = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == tkut_pkg::ENTRIES - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        tkut_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .offer_value (offer_value),
            .offer_hour  (offer_hour),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );

        // insert point: first cell the offer beats
        assign ins_pt[i] = cell_gt[i] && !left_gt;
    end

    // rank of the insert point
    always_comb begin
        ins_rank = '0;
        for (int i = 0; i < tkut_pkg::ENTRIES; i++) begin
            if (ins_pt[i]) begin
                ins_rank = tkut_pkg::RANK_W'(i);
            end
        end
    end

    assign placed     = cell_gt[tkut_pkg::ENTRIES-1];
    assign offer_rank = placed ? ins_rank : tkut_pkg::RANK_W'(tkut_pkg::ENTRIES);

    // control state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (s_tuser == tkut_pkg::REQ_DUMP) begin
                            state_reg    <= ST_DUMP;
                            cnt_reg      <= '0;
                            m_tvalid_reg <= 1'b0;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            m_tuser_reg  <= 1'b0;
                            m_tlast_reg  <= 1'b1;
                            m_tdata_reg  <= {{(tkut_pkg::M_DATA_W - 5){1'b0}},
                                             offer_rank, placed};
                        end
                    end else if (out_free) begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                ST_DUMP: begin
                    if (dump_step) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= 1'b1;
                        m_tdata_reg  <= {4'b0000, cell_entry[0].hour,
                                         cell_entry[0].value[tkut_pkg::BY_W-1:0],
                                         cell_entry[0].value[tkut_pkg::BY_W +: tkut_pkg::MB_W],
                                         cell_entry[0].value[tkut_pkg::VALUE_W-1 -: tkut_pkg::GB_W],
                                         tkut_pkg::RANK_W'(cnt_reg), 1'b0};
                        if (cnt_reg == tkut_pkg::CNT_W'(tkut_pkg::ENTRIES - 1)) begin
                            m_tlast_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_tlast_reg <= 1'b0;
                            cnt_reg     <= cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
